// ----- rtl/sgd_latent_factor_update_unit_macros.svh -----
// Assertion macros shared by the latent-factor update unit
`ifndef SGD_LATENT_FACTOR_UPDATE_UNIT_MACROS_SVH
`define SGD_LATENT_FACTOR_UPDATE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, held off during reset
`define SGDLF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sgdlf assertion failed");

// Next-cycle implication, sampled on clk_i, held off during reset
`define SGDLF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sgdlf assertion failed");

`endif

// ----- rtl/sgdlf_pkg.sv -----
// Shared types, codes and constants of the latent-factor update unit
package sgdlf_pkg;

  localparam int LATENT_LEN_DEF = 20;
  localparam int ITEM_ROWS_DEF  = 1024;
  localparam int USER_ROWS_DEF  = 4096;

  localparam int VAL_W     = 32;
  localparam int ACC_W     = 71;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_TRAIN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA = 2'd1;

  localparam logic [31:0] STEP_RESET   = 32'd4294967;
  localparam logic [31:0] LAMBDA_RESET = 32'd4294967;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_RDWAIT,
    ST_DOT,
    ST_DOT_DRAIN,
    ST_ERR,
    ST_UPD,
    ST_UPD_DRAIN,
    ST_DONE
  } sgdlf_state_e;

  typedef struct packed {
    logic                    valid;
    logic                    sat;
    logic signed [VAL_W-1:0] value;
  } sgdlf_upd_res_t;

  // Address width for a memory of the given depth
  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// ----- rtl/sgd_latent_factor_update_unit.sv -----
// Throughput: one item at a time; training is bound by the single read port of each
// table, read once for the dot product and once more for the read-modify-write pass.
// A finished result waits in the output register while the next item is taken.
// Reset: control state cleared, learning rate and lambda weight to 4294967; the
// factor tables are undefined until written and get no clearing pass.
`include "sgd_latent_factor_update_unit_macros.svh"
module sgd_latent_factor_update_unit import sgdlf_pkg::*; #(
  parameter int LATENT_LEN = LATENT_LEN_DEF,
  parameter int ITEM_ROWS  = ITEM_ROWS_DEF,
  parameter int USER_ROWS  = USER_ROWS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // item_index[9:0], user_index[21:10], element_index[26:22],
  // write_value[58:27], rating[66:59], zero fill [71:67]
  input  logic [71:0]          s_axis_tdata,
  // operation[1:0], table_select[2]
  input  logic [2:0]           s_axis_tuser,
  // Result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // read_value[31:0], prediction_error[63:32]
  output logic [63:0]          m_axis_tdata,
  // saturated[0]
  output logic                 m_axis_tuser,
  // Configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  localparam int ITEM_DEPTH = ITEM_ROWS * LATENT_LEN;
  localparam int USER_DEPTH = USER_ROWS * LATENT_LEN;
  localparam int IAW        = addr_w(ITEM_DEPTH);
  localparam int UAW        = addr_w(USER_DEPTH);
  localparam int CW         = $clog2(LATENT_LEN + 1);

  // Input fields
  logic [1:0]  in_op;
  logic        in_tsel;
  logic [9:0]  in_irow;
  logic [11:0] in_urow;
  logic [4:0]  in_elem;
  logic [31:0] in_wv;
  logic [7:0]  in_rating;
  logic        irow_ok, urow_ok, elem_ok, accept;

  assign in_op     = s_axis_tuser[1:0];
  assign in_tsel   = s_axis_tuser[2];
  assign in_irow   = s_axis_tdata[9:0];
  assign in_urow   = s_axis_tdata[21:10];
  assign in_elem   = s_axis_tdata[26:22];
  assign in_wv     = s_axis_tdata[58:27];
  assign in_rating = s_axis_tdata[66:59];

  assign irow_ok = 32'(in_irow) < ITEM_ROWS;
  assign urow_ok = 32'(in_urow) < USER_ROWS;
  assign elem_ok = 32'(in_elem) < LATENT_LEN;

  // State
  sgdlf_state_e            state_q, state_d;
  logic                    wr_q, tsel_q;
  logic [IAW-1:0]          ibase_q;
  logic [UAW-1:0]          ubase_q;
  logic [31:0]             wv_q;
  logic [7:0]              rating_q;
  logic [31:0]             step_q, lambda_q;
  logic [CW-1:0]           cnt_q, cnt_d, wcnt_q, wcnt_d;
  logic                    rdv_q, rdv_d;
  logic signed [VAL_W-1:0] err_q, err_d;
  logic                    sat_q, sat_d;
  logic [31:0]             rd_q, rd_d;
  logic                    out_valid_q, out_valid_d, out_load, out_free;
  logic [31:0]             out_rd_q, out_err_q;
  logic                    out_sat_q;

  // Memory ports
  logic           i_we, i_re, u_we, u_re;
  logic [IAW-1:0] i_waddr, i_raddr;
  logic [UAW-1:0] u_waddr, u_raddr;
  logic [31:0]    i_wdata, u_wdata, i_rdata, u_rdata;

  // Datapath links
  logic                    dot_clear, dot_busy, dot_sat;
  logic signed [VAL_W-1:0] dot_err;
  sgdlf_upd_res_t          item_res, user_res;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign dot_clear     = accept;
  assign out_free      = !out_valid_q || m_axis_tready;

  sgdlf_ram #(.WIDTH(VAL_W), .DEPTH(ITEM_DEPTH)) u_item_ram (
    .clk_i   (clk_i),
    .we_i    (i_we),
    .waddr_i (i_waddr),
    .wdata_i (i_wdata),
    .re_i    (i_re),
    .raddr_i (i_raddr),
    .rdata_o (i_rdata)
  );

  sgdlf_ram #(.WIDTH(VAL_W), .DEPTH(USER_DEPTH)) u_user_ram (
    .clk_i   (clk_i),
    .we_i    (u_we),
    .waddr_i (u_waddr),
    .wdata_i (u_wdata),
    .re_i    (u_re),
    .raddr_i (u_raddr),
    .rdata_o (u_rdata)
  );

  sgdlf_dot u_dot (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (dot_clear),
    .valid_i   (rdv_q && (state_q == ST_DOT || state_q == ST_DOT_DRAIN)),
    .a_i       ($signed(i_rdata)),
    .b_i       ($signed(u_rdata)),
    .rating_i  (rating_q),
    .busy_o    (dot_busy),
    .err_o     (dot_err),
    .err_sat_o (dot_sat)
  );

  sgdlf_upd u_upd_item (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (rdv_q && (state_q == ST_UPD || state_q == ST_UPD_DRAIN)),
    .own_i    ($signed(i_rdata)),
    .other_i  ($signed(u_rdata)),
    .err_i    (err_q),
    .step_i   (step_q),
    .lambda_i (lambda_q),
    .res_o    (item_res)
  );

  sgdlf_upd u_upd_user (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (rdv_q && (state_q == ST_UPD || state_q == ST_UPD_DRAIN)),
    .own_i    ($signed(u_rdata)),
    .other_i  ($signed(i_rdata)),
    .err_i    (err_q),
    .step_i   (step_q),
    .lambda_i (lambda_q),
    .res_o    (user_res)
  );

  // Next state, memory control and result capture
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    wcnt_d      = wcnt_q;
    rdv_d       = 1'b0;
    err_d       = err_q;
    sat_d       = sat_q;
    rd_d        = rd_q;
    out_load    = 1'b0;
    i_we        = 1'b0;
    u_we        = 1'b0;
    i_re        = 1'b0;
    u_re        = 1'b0;
    i_waddr     = ibase_q;
    u_waddr     = ubase_q;
    i_raddr     = ibase_q;
    u_raddr     = ubase_q;
    i_wdata     = wv_q;
    u_wdata     = wv_q;

    // Write back updated elements as they leave the pipelines
    if (item_res.valid) begin
      i_we    = 1'b1;
      u_we    = 1'b1;
      i_waddr = ibase_q + IAW'(wcnt_q);
      u_waddr = ubase_q + UAW'(wcnt_q);
      i_wdata = item_res.value;
      u_wdata = user_res.value;
      wcnt_d  = wcnt_q + 1'b1;
      sat_d   = sat_q | item_res.sat | user_res.sat;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_d  = '0;
          wcnt_d = '0;
          err_d  = '0;
          sat_d  = 1'b0;
          rd_d   = '0;
          state_d = ST_DONE;
          if ((in_op == OP_WRITE || in_op == OP_READ) && elem_ok
              && ((!in_tsel && irow_ok) || (in_tsel && urow_ok))) begin
            state_d = ST_ACCESS;
          end else if (in_op == OP_TRAIN && irow_ok && urow_ok) begin
            state_d = ST_DOT;
          end
        end
      end
      ST_ACCESS: begin
        if (wr_q) begin
          i_we    = !tsel_q;
          u_we    = tsel_q;
          state_d = ST_DONE;
        end else begin
          i_re    = !tsel_q;
          u_re    = tsel_q;
          state_d = ST_RDWAIT;
        end
      end
      ST_RDWAIT: begin
        rd_d    = tsel_q ? u_rdata : i_rdata;
        state_d = ST_DONE;
      end
      ST_DOT, ST_UPD: begin
        i_re    = 1'b1;
        u_re    = 1'b1;
        i_raddr = ibase_q + IAW'(cnt_q);
        u_raddr = ubase_q + UAW'(cnt_q);
        rdv_d   = 1'b1;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CW'(LATENT_LEN - 1)) begin
          cnt_d   = '0;
          state_d = (state_q == ST_DOT) ? ST_DOT_DRAIN : ST_UPD_DRAIN;
        end
      end
      ST_DOT_DRAIN: begin
        if (!rdv_q && !dot_busy) begin
          state_d = ST_ERR;
        end
      end
      ST_ERR: begin
        err_d   = dot_err;
        sat_d   = sat_q | dot_sat;
        wcnt_d  = '0;
        state_d = ST_UPD;
      end
      ST_UPD_DRAIN: begin
        if (wcnt_q == CW'(LATENT_LEN)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_valid_d = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      wcnt_q      <= '0;
      rdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
      step_q      <= STEP_RESET;
      lambda_q    <= LAMBDA_RESET;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      wcnt_q      <= wcnt_d;
      rdv_q       <= rdv_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_STEP) begin
          step_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_LAMBDA) begin
          lambda_q <= cfg_data_i;
        end
      end
    end
  end

  // Transaction fields and results
  always_ff @(posedge clk_i) begin
    err_q <= err_d;
    sat_q <= sat_d;
    rd_q  <= rd_d;
    if (accept) begin
      wr_q     <= (in_op == OP_WRITE);
      tsel_q   <= in_tsel;
      wv_q     <= in_wv;
      rating_q <= in_rating;
      ibase_q  <= IAW'(32'(in_irow) * LATENT_LEN
                  + ((in_op == OP_TRAIN) ? 32'd0 : 32'(in_elem)));
      ubase_q  <= UAW'(32'(in_urow) * LATENT_LEN
                  + ((in_op == OP_TRAIN) ? 32'd0 : 32'(in_elem)));
    end
    if (out_load) begin
      out_rd_q  <= rd_q;
      out_err_q <= err_q;
      out_sat_q <= sat_q;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_err_q, out_rd_q};
  assign m_axis_tuser  = out_sat_q;

  // Checks
  `SGDLF_ASSERT_IMPL(a_no_write_idle, state_q == ST_IDLE, !i_we && !u_we)
  `SGDLF_ASSERT_IMPL(a_wcnt_bound, 1'b1, wcnt_q <= CW'(LATENT_LEN))
  `SGDLF_ASSERT_IMPL(a_upd_in_phase, item_res.valid,
                     state_q == ST_UPD || state_q == ST_UPD_DRAIN)
  `SGDLF_ASSERT_NEXT(a_load_from_done, out_load, out_valid_q && state_q == ST_IDLE)

endmodule

// ----- rtl/sgdlf_ram.sv -----
// Generic simple dual-port RAM with registered read
module sgdlf_ram import sgdlf_pkg::*; #(
  parameter int WIDTH = VAL_W,
  parameter int DEPTH = 2
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [addr_w(DEPTH)-1:0]  waddr_i,
  input  logic [WIDTH-1:0]          wdata_i,
  input  logic                      re_i,
  input  logic [addr_w(DEPTH)-1:0]  raddr_i,
  output logic [WIDTH-1:0]          rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/sgdlf_dot.sv -----
// Dot-product accumulator and saturated prediction error
module sgdlf_dot import sgdlf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    clear_i,
  input  logic                    valid_i,
  input  logic signed [VAL_W-1:0] a_i,
  input  logic signed [VAL_W-1:0] b_i,
  input  logic [7:0]              rating_i,
  output logic                    busy_o,
  output logic signed [VAL_W-1:0] err_o,
  output logic                    err_sat_o
);

  logic                    prod_v_q;
  logic signed [63:0]      prod_q;
  logic signed [63:0]      prod_d;
  logic signed [ACC_W-1:0] acc_q;
  logic [38:0]             hi;
  logic [31:0]             lo;
  logic [40:0]             e_raw;
  logic signed [40:0]      e_s;

  assign prod_d = a_i * b_i;

  // Register one product per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else begin
      prod_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // Accumulate exact Q15.56 sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (clear_i) begin
      acc_q <= '0;
    end else if (prod_v_q) begin
      acc_q <= acc_q + {{(ACC_W-64){prod_q[63]}}, prod_q};
    end
  end

  // Error: rating minus dot/2^32, round half up, clamp to 32 bits
  assign hi    = acc_q[ACC_W-1:32];
  assign lo    = acc_q[31:0];
  assign e_raw = {9'b0, rating_i, 24'b0} - {{2{hi[38]}}, hi}
               - {40'b0, (lo > 32'h8000_0000)};
  assign e_s   = $signed(e_raw);

  always_comb begin
    err_sat_o = 1'b0;
    err_o     = e_s[VAL_W-1:0];
    if (e_s > 41'sd2147483647) begin
      err_sat_o = 1'b1;
      err_o     = 32'sh7fff_ffff;
    end else if (e_s < -41'sd2147483648) begin
      err_sat_o = 1'b1;
      err_o     = 32'sh8000_0000;
    end
  end

  assign busy_o = prod_v_q;

endmodule

// ----- rtl/sgdlf_upd.sv -----
// Five-stage element update: own + step*(err*other - lambda*own)
module sgdlf_upd import sgdlf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic signed [VAL_W-1:0] own_i,
  input  logic signed [VAL_W-1:0] other_i,
  input  logic signed [VAL_W-1:0] err_i,
  input  logic [31:0]             step_i,
  input  logic [31:0]             lambda_i,
  output sgdlf_upd_res_t          res_o
);

  logic [3:0]              v_q;
  logic signed [VAL_W-1:0] own1_q, own2_q, own3_q, own4_q;
  logic signed [63:0]      m1_q, m1_d;
  logic signed [64:0]      m2_q, m2_d;
  logic signed [32:0]      lam_s, step_s;
  logic signed [65:0]      grad_q;
  logic signed [33:0]      gh;
  logic [63:0]             pl_q;
  logic signed [66:0]      ph_q, ph_d;
  logic signed [66:0]      a_q;
  logic signed [66:0]      r;
  logic signed [43:0]      sum;
  logic                    res_valid_q;
  logic                    res_sat_q;
  logic signed [VAL_W-1:0] res_value_q;
  sgdlf_upd_res_t          res_d;

  assign lam_s  = {1'b0, lambda_i};
  assign step_s = {1'b0, step_i};
  assign m1_d   = err_i * other_i;
  assign m2_d   = lam_s * own_i;
  assign gh     = grad_q[65:32];
  assign ph_d   = step_s * gh;

  // Advance the valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      v_q         <= {v_q[2:0], valid_i};
      res_valid_q <= res_d.valid;
    end
  end

  // Datapath stages
  always_ff @(posedge clk_i) begin
    m1_q   <= m1_d;
    m2_q   <= m2_d;
    own1_q <= own_i;
    grad_q <= {{2{m1_q[63]}}, m1_q} - {m2_q[64], (m2_q >>> 8)};
    own2_q <= own1_q;
    pl_q   <= step_i * grad_q[31:0];
    ph_q   <= ph_d;
    own3_q <= own2_q;
    a_q    <= ph_q + $signed({35'b0, pl_q[63:32]});
    own4_q <= own3_q;
    res_sat_q   <= res_d.sat;
    res_value_q <= res_d.value;
  end

  // Round delta half up, add and clamp
  assign r   = a_q + 67'sd8388608;
  assign sum = {{12{own4_q[31]}}, own4_q} + 44'(r >>> 24);

  always_comb begin
    res_d.valid = v_q[3];
    res_d.sat   = 1'b0;
    res_d.value = sum[VAL_W-1:0];
    if (sum > 44'sd2147483647) begin
      res_d.sat   = 1'b1;
      res_d.value = 32'sh7fff_ffff;
    end else if (sum < -44'sd2147483648) begin
      res_d.sat   = 1'b1;
      res_d.value = 32'sh8000_0000;
    end
  end

  assign res_o = {res_valid_q, res_sat_q, res_value_q};

endmodule
